>>> design/mixed_graph_reachability_update_core_defines.svh
// Assertion macros for the mixed graph reachability core.
`ifndef MIXED_GRAPH_REACHABILITY_UPDATE_CORE_DEFINES_SVH
`define MIXED_GRAPH_REACHABILITY_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MGRU_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MGRU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mgru_pkg.sv
// Types and constants shared by the mixed graph reachability core and its channels.
package mgru_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned ROW_W         = 64;
  localparam int unsigned NODE_W        = 6;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CNT_W         = 7;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_DIR  = 2'd0,
    MODE_BID  = 2'd1,
    MODE_SIMP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DIR,
    OP_BID,
    OP_SIMP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_RD1,
    ST_PRE_RD2,
    ST_PRE_WR1,
    ST_PRE_WR2,
    ST_WALK,
    ST_DONE
  } state_e;

endpackage

>>> design/mgru_intf.sv
// Valid/ready channel interfaces: input items, result items and configuration writes.
interface mgru_in_if;
  import mgru_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [ROW_W-1:0]  future_mask;
  logic              strip_direct;
  modport source (output valid, mode, node_a, node_b, future_mask, strip_direct,
                  input ready);
  modport sink   (input valid, mode, node_a, node_b, future_mask, strip_direct,
                  output ready);
endinterface

interface mgru_out_if;
  logic valid;
  logic ready;
  logic cycle_found;
  logic rejected;
  modport source (output valid, cycle_found, rejected, input ready);
  modport sink   (input valid, cycle_found, rejected, output ready);
endinterface

interface mgru_cfg_if;
  import mgru_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

>>> design/mixed_graph_reachability_update_core.sv
// Top level: incremental reachability over directed and bidirected edges.
//
// Channels: in_i takes one item (mode, node_a, node_b, future_mask,
// strip_direct); out_o gives one result item (cycle_found, rejected) per item.
// cfg_i writes node_count at any handshake; it is always ready and must only
// be used while no item is in flight.
// Two row memories (direct and almost, MaxNodes rows of 64 bits, registered
// read) hold the state. An item first patches the edge rows (two reads and
// one write for a directed edge, two reads and two writes for a bidirected
// one), then walks every row below the limit n with one read-modify-write per
// cycle, checking the diagonal of each final row on the way. One item is in
// work at a time; the row walk over the single write port of each memory sets
// the rate.
// Reset clears every row at once through per-row valid bits; node_count
// returns to 64. A result waiting on a stalled receiver is held in the output
// register; a following item is accepted and worked on, and holds at its
// end until the output register is free.
`include "mixed_graph_reachability_update_core_defines.svh"

module mixed_graph_reachability_update_core #(
  parameter int unsigned MaxNodes = mgru_pkg::MAX_NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mgru_cfg_if.sink          cfg_i,
  mgru_in_if.sink           in_i,
  mgru_out_if.source        out_o
);
  import mgru_pkg::*;

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam int unsigned NW = $clog2(MaxNodes + 1);

  // Row memories and per-row valid bits (unwritten rows read as zero).
  logic [ROW_W-1:0]    dmem [MaxNodes];
  logic [ROW_W-1:0]    amem [MaxNodes];
  logic [MaxNodes-1:0] row_vld_q;
  logic [ROW_W-1:0]    dmem_rd_q, amem_rd_q;
  logic                rd_vld_q;
  logic [ROW_W-1:0]    rd_d, rd_a;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [ROW_W-1:0]    mem_wd, mem_wa;

  state_e              state_q, state_d;
  op_e                 op_q, op_d, op_in;
  logic                rej_q, rej_d, rej_in;
  logic [NODE_W-1:0]   na_q, na_d, nb_q, nb_d;
  logic [ROW_W-1:0]    fm_q, fm_d;
  logic                strip_q, strip_d;
  logic                cyc_q, cyc_d;
  logic [ROW_W-1:0]    r1d_q, r1d_d, r1a_q, r1a_d, r2d_q, r2d_d, r2a_q, r2a_d;
  logic [NW-1:0]       ws_q, ws_d;
  logic                pv_q, pv_d;
  logic [AW-1:0]       pa_q, pa_d;
  logic [CNT_W-1:0]    node_count_q, node_count_d;
  logic                out_valid_q, out_valid_d;
  logic                out_cyc_q, out_cyc_d, out_rej_q, out_rej_d;

  logic [NW-1:0]       lim;
  logic                in_acc, out_load, a_in, b_in;
  logic [ROW_W-1:0]    bit_a, bit_b, new_aa;
  logic [NODE_W-1:0]   pz;
  logic [ROW_W-1:0]    wk_d, wk_a, dc;
  logic                wk_self;

  // Node limit, saturated to the number of rows.
  assign lim = (node_count_q > CNT_W'(MaxNodes)) ? NW'(MaxNodes) : node_count_q[NW-1:0];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.cycle_found = out_cyc_q;
  assign out_o.rejected    = out_rej_q;

  assign rd_d = rd_vld_q ? dmem_rd_q : '0;
  assign rd_a = rd_vld_q ? amem_rd_q : '0;

  assign bit_a  = ROW_W'(1) << na_q;
  assign bit_b  = ROW_W'(1) << nb_q;
  assign pz     = NODE_W'(pa_q);
  // Row a after its bidirected patch; also row b's base when a equals b.
  assign new_aa = r1a_q | bit_b | rd_d;

  // Decode of an incoming item.
  assign a_in = CNT_W'(in_i.node_a) < CNT_W'(lim);
  assign b_in = CNT_W'(in_i.node_b) < CNT_W'(lim);

  always_comb begin
    op_in  = OP_NONE;
    rej_in = 1'b1;
    case (in_i.mode)
      MODE_DIR: begin
        if (a_in && b_in && (in_i.node_a != in_i.node_b)) begin
          op_in  = OP_DIR;
          rej_in = 1'b0;
        end
      end
      MODE_BID: begin
        if (a_in && b_in) begin
          op_in  = OP_BID;
          rej_in = 1'b0;
        end
      end
      MODE_SIMP: begin
        op_in  = OP_SIMP;
        rej_in = 1'b0;
      end
      default: begin
        op_in  = OP_NONE;
        rej_in = 1'b1;
      end
    endcase
  end

  // Row update during the walk; the row read last cycle sits in rd_d/rd_a.
  always_comb begin
    wk_d = rd_d;
    wk_a = rd_a;
    dc   = r1d_q;
    case (op_q)
      OP_DIR: begin
        if (rd_d[na_q]) begin
          wk_d = rd_d | bit_b | r1d_q;
          wk_a = rd_a | r1a_q;
        end
        // On the child's own row its direct row has just changed.
        if (pa_q == nb_q[AW-1:0]) begin
          dc = wk_d;
        end
        if (wk_a[na_q]) begin
          wk_a = wk_a | bit_b | dc;
        end
      end
      OP_BID: begin
        if (rd_d[na_q]) begin
          wk_a = wk_a | bit_b | r2d_q;
        end
        if (rd_d[nb_q]) begin
          wk_a = wk_a | bit_a | r1d_q;
        end
      end
      OP_SIMP: begin
        if (!fm_q[pz]) begin
          wk_d = '0;
          wk_a = '0;
        end
        if (strip_q) begin
          wk_a = wk_a & ~wk_d;
        end
      end
      default: begin
        wk_d = rd_d;
        wk_a = rd_a;
      end
    endcase
  end

  assign wk_self = wk_d[pz] | wk_a[pz];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_in == OP_DIR || op_in == OP_BID) ? ST_PRE_RD1 : ST_WALK;
        end
      end
      ST_PRE_RD1: state_d = ST_PRE_RD2;
      ST_PRE_RD2: state_d = ST_PRE_WR1;
      ST_PRE_WR1: state_d = (op_q == OP_BID) ? ST_PRE_WR2 : ST_WALK;
      ST_PRE_WR2: state_d = ST_WALK;
      ST_WALK: begin
        if (ws_q == lim) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d         = op_q;
    rej_d        = rej_q;
    na_d         = na_q;
    nb_d         = nb_q;
    fm_d         = fm_q;
    strip_d      = strip_q;
    cyc_d        = cyc_q;
    r1d_d        = r1d_q;
    r1a_d        = r1a_q;
    r2d_d        = r2d_q;
    r2a_d        = r2a_q;
    ws_d         = ws_q;
    pv_d         = 1'b0;
    pa_d         = pa_q;
    mem_re       = 1'b0;
    mem_raddr    = ws_q[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = pa_q;
    mem_wd       = wk_d;
    mem_wa       = wk_a;
    node_count_d = cfg_i.valid ? cfg_i.node_count : node_count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_cyc_d    = out_cyc_q;
    out_rej_d    = out_rej_q;

    // Directed edge: first row is the child, second the parent.
    // Bidirected edge: first row is node_a, second node_b.
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = op_in;
          rej_d   = rej_in;
          na_d    = in_i.node_a;
          nb_d    = in_i.node_b;
          fm_d    = in_i.future_mask;
          strip_d = in_i.strip_direct;
          cyc_d   = 1'b0;
          ws_d    = '0;
        end
      end
      ST_PRE_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = (op_q == OP_DIR) ? nb_q[AW-1:0] : na_q[AW-1:0];
      end
      ST_PRE_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = (op_q == OP_DIR) ? na_q[AW-1:0] : nb_q[AW-1:0];
        r1d_d     = rd_d;
        r1a_d     = rd_a;
      end
      ST_PRE_WR1: begin
        mem_we = 1'b1;
        if (op_q == OP_DIR) begin
          mem_waddr = na_q[AW-1:0];
          mem_wd    = rd_d | bit_b | r1d_q;
          mem_wa    = rd_a | r1a_q;
        end else begin
          mem_waddr = na_q[AW-1:0];
          mem_wd    = r1d_q;
          mem_wa    = new_aa;
          r1a_d     = new_aa;
          r2d_d     = rd_d;
          r2a_d     = rd_a;
        end
      end
      ST_PRE_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = nb_q[AW-1:0];
        mem_wd    = r2d_q;
        mem_wa    = ((na_q == nb_q) ? r1a_q : r2a_q) | bit_a | r1d_q;
      end
      ST_WALK: begin
        if (ws_q < lim) begin
          mem_re = 1'b1;
          ws_d   = ws_q + NW'(1);
          pv_d   = 1'b1;
          pa_d   = ws_q[AW-1:0];
        end
        if (pv_q) begin
          mem_we = (op_q != OP_NONE);
          cyc_d  = cyc_q | wk_self;
          if (op_q == OP_DIR && pa_q == nb_q[AW-1:0]) begin
            r1d_d = wk_d;
            r1a_d = wk_a;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_cyc_d   = cyc_q;
          out_rej_d   = rej_q;
        end
      end
      default: begin
        pv_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ws_q         <= '0;
      pv_q         <= 1'b0;
      node_count_q <= NODE_COUNT_RST;
      out_valid_q  <= 1'b0;
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      ws_q         <= ws_d;
      pv_q         <= pv_d;
      node_count_q <= node_count_d;
      out_valid_q  <= out_valid_d;
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= row_vld_q[mem_raddr];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    rej_q     <= rej_d;
    na_q      <= na_d;
    nb_q      <= nb_d;
    fm_q      <= fm_d;
    strip_q   <= strip_d;
    cyc_q     <= cyc_d;
    r1d_q     <= r1d_d;
    r1a_q     <= r1a_d;
    r2d_q     <= r2d_d;
    r2a_q     <= r2a_d;
    pa_q      <= pa_d;
    out_cyc_q <= out_cyc_d;
    out_rej_q <= out_rej_d;
  end

  // Row memories: one write and one read port each, read data registered.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wd;
      amem[mem_waddr] <= mem_wa;
    end
    if (mem_re) begin
      dmem_rd_q <= dmem[mem_raddr];
      amem_rd_q <= amem[mem_raddr];
    end
  end

  `MGRU_ASSERT_IMPL(a_proc_only_in_walk, pv_q, state_q == ST_WALK, "row processed outside walk")
  `MGRU_ASSERT_NEXT(a_accept_starts_work, in_acc, state_q != ST_IDLE, "accepted item not started")
  `MGRU_ASSERT_IMPL(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result not from done")

endmodule

>>> tb/sv/mgru_reach_checker.sv
`timescale 1ns / 1ps
// Reachability scoreboard: tracks both row matrices and checks every result item against them.
module mgru_reach_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mgru_cfg_if  cfg_i,
  mgru_in_if   in_i,
  mgru_out_if  res_i,
  output int   err_count_o
);
  import mgru_pkg::*;

  typedef struct packed {
    logic cycle_found;
    logic rejected;
  } reach_res_t;

  logic [ROW_W-1:0] dir_reach [MAX_NODES_DEF];
  logic [ROW_W-1:0] bid_reach [MAX_NODES_DEF];
  logic [CNT_W-1:0] count_q;
  reach_res_t       pending_res_q [$];
  int               errors = 0;

  assign err_count_o = errors;

  function automatic int unsigned active_limit();
    if (count_q > CNT_W'(MAX_NODES_DEF)) return MAX_NODES_DEF;
    return int'(count_q);
  endfunction

  function automatic logic [ROW_W-1:0] node_bit(input int unsigned i);
    logic [ROW_W-1:0] one;
    one = ROW_W'(1);
    return one << i;
  endfunction

  // In place, ascending rows: later rows see what earlier ones just gained.
  function automatic void link_directed(input int unsigned p, input int unsigned c,
                                        input int unsigned n);
    logic [ROW_W-1:0] pb, cb;
    pb = node_bit(p);
    cb = node_bit(c);
    dir_reach[p] |= cb;
    dir_reach[p] |= dir_reach[c];
    bid_reach[p] |= bid_reach[c];
    for (int unsigned z = 0; z < n; z++) begin
      if ((dir_reach[z] & pb) != '0) begin
        dir_reach[z] |= cb;
        dir_reach[z] |= dir_reach[c];
        bid_reach[z] |= bid_reach[c];
      end
      if ((bid_reach[z] & pb) != '0) begin
        bid_reach[z] |= cb;
        bid_reach[z] |= dir_reach[c];
      end
    end
  endfunction

  function automatic void link_bidirected(input int unsigned a, input int unsigned b,
                                          input int unsigned n);
    logic [ROW_W-1:0] ab, bb;
    ab = node_bit(a);
    bb = node_bit(b);
    bid_reach[a] |= bb;
    bid_reach[a] |= dir_reach[b];
    bid_reach[b] |= ab;
    bid_reach[b] |= dir_reach[a];
    for (int unsigned z = 0; z < n; z++) begin
      if ((dir_reach[z] & ab) != '0) begin
        bid_reach[z] |= bb;
        bid_reach[z] |= dir_reach[b];
      end
      if ((dir_reach[z] & bb) != '0) begin
        bid_reach[z] |= ab;
        bid_reach[z] |= dir_reach[a];
      end
    end
  endfunction

  function automatic void prune_rows(input logic [ROW_W-1:0] keep, input logic strip,
                                     input int unsigned n);
    for (int unsigned z = 0; z < n; z++) begin
      if (!keep[z]) begin
        dir_reach[z] = '0;
        bid_reach[z] = '0;
      end
      if (strip) bid_reach[z] &= ~dir_reach[z];
    end
  endfunction

  function automatic logic any_self_reach(input int unsigned n);
    for (int unsigned x = 0; x < n; x++) begin
      if (dir_reach[x][x] || bid_reach[x][x]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reach_res_t apply_item(input logic [MODE_W-1:0] m,
                                            input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            input logic [ROW_W-1:0] keep,
                                            input logic strip);
    int unsigned n;
    reach_res_t  r;
    n = active_limit();
    r.rejected = 1'b0;
    case (m)
      MODE_DIR: begin
        if (a >= n || b >= n || a == b) r.rejected = 1'b1;
        else link_directed(a, b, n);
      end
      MODE_BID: begin
        if (a >= n || b >= n) r.rejected = 1'b1;
        else link_bidirected(a, b, n);
      end
      MODE_SIMP: prune_rows(keep, strip, n);
      default:   r.rejected = 1'b1;
    endcase
    r.cycle_found = any_self_reach(n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reach_res_t got, want;
    if (!rst_ni) begin
      count_q = NODE_COUNT_RST;
      for (int unsigned i = 0; i < MAX_NODES_DEF; i++) begin
        dir_reach[i] = '0;
        bid_reach[i] = '0;
      end
      pending_res_q.delete();
    end else begin
      // results first: a result can never belong to an item taken at the same edge
      if (res_i.valid && res_i.ready) begin
        got.cycle_found = res_i.cycle_found;
        got.rejected    = res_i.rejected;
        if (pending_res_q.size() == 0) begin
          errors++;
          $error("result item with none expected: cycle_found %0b rejected %0b",
                 got.cycle_found, got.rejected);
        end else begin
          want = pending_res_q.pop_front();
          if (got.cycle_found !== want.cycle_found) begin
            errors++;
            $error("cycle_found: expected %0b, got %0b", want.cycle_found, got.cycle_found);
          end
          if (got.rejected !== want.rejected) begin
            errors++;
            $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) count_q = cfg_i.node_count;
      if (in_i.valid && in_i.ready)
        pending_res_q.push_back(apply_item(in_i.mode, in_i.node_a, in_i.node_b,
                                           in_i.future_mask, in_i.strip_direct));
    end
  end

  final begin
    if (pending_res_q.size() != 0)
      $error("%0d result items never arrived", pending_res_q.size());
  end

endmodule

>>> tb/sv/mixed_graph_reachability_update_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, item and result traffic, node count phases and the verdict.
module mixed_graph_reachability_update_core_tb;
  import mgru_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned       HOLD_CYCLES = 400;
  localparam int unsigned       N_PHASES    = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned src_max_gap  = 8;
  int unsigned sink_max_stall = 8;
  int unsigned cur_count    = NODE_COUNT_RST;
  bit          hold_pending = 1'b0;
  int          check_errors;

  int unsigned phase_nodes [N_PHASES] = '{8, 1, 0, 127, 64, 2, 16, 33, 65, 5, 64, 40};
  int unsigned phase_items [N_PHASES] = '{90, 30, 20, 70, 110, 40, 90, 80, 60, 70, 120, 140};

  mgru_cfg_if cfg_if ();
  mgru_in_if  in_if ();
  mgru_out_if out_if ();

  mixed_graph_reachability_update_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mgru_reach_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_if),
    .in_i        (in_if),
    .res_i       (out_if),
    .err_count_o (check_errors)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("mixed_graph_reachability_update_core_tb: errors");
    $finish;
  end

  // valid stays high across back-to-back items; it is only lowered for a gap or in settle()
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [ROW_W-1:0] keep,
                           input logic strip);
    int unsigned gap;
    gap = $urandom_range(src_max_gap, 0);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= m;
    in_if.node_a       <= a;
    in_if.node_b       <= b;
    in_if.future_mask  <= keep;
    in_if.strip_direct <= strip;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int unsigned v);
    cfg_if.valid      <= 1'b1;
    cfg_if.node_count <= CNT_W'(v);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_count = v;
    @(posedge clk_i);
  endtask

  // Mostly in-range edges so that reachability builds up, some simplify items; the rest probes refusals.
  task automatic send_random_item();
    int unsigned      n, pick, shape;
    logic [NODE_W-1:0] a, b;
    logic [ROW_W-1:0]  keep;
    logic              strip;
    n     = (cur_count > MAX_NODES_DEF) ? MAX_NODES_DEF : cur_count;
    pick  = $urandom_range(99, 0);
    a     = NODE_W'($urandom_range(63, 0));
    b     = NODE_W'($urandom_range(63, 0));
    keep  = {$urandom, $urandom};
    strip = 1'($urandom_range(1, 0));
    if (n != 0 && pick < 84) begin
      a = NODE_W'($urandom_range(n - 1, 0));
      b = NODE_W'($urandom_range(n - 1, 0));
    end
    if (pick < 50) send_item(MODE_DIR, a, b, keep, strip);
    else if (pick < 72) send_item(MODE_BID, a, b, keep, strip);
    else if (pick < 84) begin
      shape = $urandom_range(3, 0);
      case (shape)
        0: keep = ~({$urandom, $urandom} & {$urandom, $urandom});
        1: keep = {$urandom, $urandom} & {$urandom, $urandom};
        2: ;
        default: keep = strip ? '1 : '0;
      endcase
      send_item(MODE_SIMP, a, b, keep, strip);
    end
    else if (pick < 92) send_item(MODE_DIR, a, b, keep, strip);
    else if (pick < 97) send_item(MODE_BID, a, b, keep, strip);
    else send_item(MODE_UNUSED, a, b, keep, strip);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        out_if.ready <= 1'b0;
        for (int unsigned k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_pending = 1'b0;
      end else begin
        stall = $urandom_range(sink_max_stall, 0);
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_seen++;
    end
  end

  initial begin : stimulus
    cfg_if.valid       <= 1'b0;
    cfg_if.node_count  <= NODE_COUNT_RST;
    in_if.valid        <= 1'b0;
    in_if.mode         <= MODE_DIR;
    in_if.node_a       <= '0;
    in_if.node_b       <= '0;
    in_if.future_mask  <= '0;
    in_if.strip_direct <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fixed item sequence at the reset node count
    send_item(MODE_DIR,    6'd0,  6'd63, '0, 1'b0);
    send_item(MODE_DIR,    6'd63, 6'd0,  '0, 1'b0);   // closes a loop
    send_item(MODE_DIR,    6'd5,  6'd5,  '0, 1'b0);   // self edge refused
    send_item(MODE_SIMP,   6'd0,  6'd0,  '1, 1'b0);
    send_item(MODE_SIMP,   6'd63, 6'd63, '0, 1'b1);   // wipes everything
    send_item(MODE_BID,    6'd7,  6'd7,  '0, 1'b0);   // bidirected self loop is legal
    send_item(MODE_SIMP,   6'd0,  6'd0,  ~(64'd1 << 7), 1'b0);
    send_item(MODE_DIR,    6'd1,  6'd2,  '0, 1'b0);
    send_item(MODE_DIR,    6'd2,  6'd3,  '0, 1'b0);
    send_item(MODE_BID,    6'd3,  6'd4,  '0, 1'b0);
    send_item(MODE_DIR,    6'd4,  6'd1,  '0, 1'b0);
    send_item(MODE_SIMP,   6'd0,  6'd0,  '1, 1'b1);
    send_item(MODE_UNUSED, 6'd63, 6'd0,  '1, 1'b1);
    send_item(MODE_BID,    6'd63, 6'd0,  '0, 1'b0);
    send_item(MODE_DIR,    6'd62, 6'd63, '0, 1'b0);
    send_item(MODE_SIMP,   6'd0,  6'd0,  '1, 1'b1);
    send_item(MODE_BID,    6'd0,  6'd63, '0, 1'b0);
    send_item(MODE_SIMP,   6'd0,  6'd0,  64'h8000_0000_0000_0001, 1'b0);
    send_item(MODE_DIR,    6'd63, 6'd62, '0, 1'b0);
    send_item(MODE_SIMP,   6'd21, 6'd42, '0, 1'b0);
    settle();

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_node_count(phase_nodes[p]);
      src_max_gap    = (p % 3 == 2) ? 0 : 8;
      sink_max_stall = (p % 4 == 1) ? 0 : 8;
      if (p == 4) begin
        // receiver stops for a long stretch while items keep coming
        src_max_gap  = 0;
        hold_pending = 1'b1;
      end
      for (int unsigned i = 0; i < phase_items[p]; i++) send_random_item();
      settle();
    end

    repeat (80) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("mixed_graph_reachability_update_core_tb: clean");
    end else begin
      $display("mixed_graph_reachability_update_core_tb: errors");
    end
    $finish;
  end

endmodule
